FILE: sv/pba_pkg.sv
// Shared types, codes and sizes of the bitmap page allocator.
`timescale 1ns / 1ps
`default_nettype none
package pba_pkg;

  localparam int PAGES      = 32768;
  localparam int PAGE_SHIFT = 12;

  // One byte of the bitmap covers eight pages.
  localparam int WORDS = PAGES / 8;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

  // Width for page numbers and limits: a word index with its bit offset, and
  // 17 bits so that a count of 32768 and a 16-bit range end both fit.
  localparam int PW        = ((AW + 4) > 17) ? (AW + 4) : 17;
  localparam int LIMIT_CAP = (PAGES < 32768) ? PAGES : 32768;

  localparam logic [7:0] FULL_BYTE = 8'hFF;

  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_FREE    = 2'd1;
  localparam logic [1:0] CMD_RESERVE = 2'd2;

  localparam logic REG_BASE_ADDRESS  = 1'b0;
  localparam logic REG_PRESENT_PAGES = 1'b1;

  typedef struct packed {
    logic [1:0]  command;
    logic [14:0] page_index;
    logic [15:0] range_end;
  } request_t;

  typedef struct packed {
    logic [31:0] address;
    logic [14:0] allocated_page;
    logic        failed;
  } result_t;

  // Access to the bitmap store: one write and one read address per cycle.
  typedef struct packed {
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [AW-1:0] rd_addr;
  } store_req_t;

endpackage
`default_nettype wire

FILE: sv/pba_store.sv
// Bitmap store of the page allocator with its clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
module pba_store import pba_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire store_req_t store_req,
  output logic [7:0]      rd_data,
  output logic            clearing
);

  logic [7:0]    mem [WORDS];
  logic [AW-1:0] clr_addr;

  // Sweep every byte to zero, one per cycle, then hand the port over.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(WORDS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (store_req.wr_en) begin
      mem[store_req.wr_addr] <= store_req.wr_data;
    end
    rd_data <= mem[store_req.rd_addr];
  end

endmodule
`default_nettype wire

FILE: sv/page_bitmap_allocator.sv
// Top level of the first-fit bitmap page allocator.
`timescale 1ns / 1ps
`default_nettype none
// First-fit page allocator over a bitmap of one used bit per page, held in a
// byte-wide synchronous memory (PAGES/8 bytes). After reset the block runs a
// clearing pass over every byte with busy high; configuration writes are
// taken during it. A request is taken when start is high and busy is low;
// its single result appears on result, marked by done for exactly one cycle,
// and the receiver cannot hold it off. The memory port moves one bitmap byte
// per cycle: allocate reads the bytes in order from byte 0 until one holds a
// free page below the limit, and fails once a byte starts at or above the
// limit or its first free page lies there; free reads the byte and writes it
// back with the bit cleared; reserve writes each byte the range spans in
// turn; an empty range, a free beyond the store and the unused command answer
// without a memory access. busy drops in the cycle done is shown, so the next
// request can follow at once. allocate returns base_address + (page <<
// PAGE_SHIFT) modulo 2^32 and never hands out a page at or above
// present_pages; a failed allocate returns address 0, page 0 and failed
// high. free and reserve echo page_index with address 0.
module page_bitmap_allocator import pba_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire request_t    request,
  output logic             done,
  output result_t          result,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_FREE = 4'b0100,
    S_RESV = 4'b1000
  } state_t;

  state_t        state, state_next;
  request_t      req_q, req_q_next;
  logic [AW:0]   cur, cur_next;          // word under scan or reserve
  logic [AW-1:0] last_word, last_word_next;
  logic [2:0]    lo_bit, lo_bit_next;
  logic [2:0]    hi_bit, hi_bit_next;
  logic          done_next;
  result_t       result_next;

  logic [31:0]   base_address;
  logic [15:0]   present_pages;

  store_req_t    store_req;
  logic [7:0]    rd_data;
  logic          clearing;

  pba_store u_store (
    .clk       (clk),
    .rst       (rst),
    .store_req (store_req),
    .rd_data   (rd_data),
    .clearing  (clearing)
  );

  // Lowest clear bit of a byte; only used when the byte is not full.
  function automatic logic [2:0] first_zero(input logic [7:0] bits);
    logic [2:0] pos;
    pos = 3'd0;
    for (int b = 7; b >= 0; b--) begin
      if (!bits[b]) pos = 3'(b);
    end
    return pos;
  endfunction

  // Bits lo..hi of one byte set.
  function automatic logic [7:0] span_mask(input logic [2:0] lo, input logic [2:0] hi);
    logic [7:0] m;
    for (int b = 0; b < 8; b++) begin
      m[b] = (3'(b) >= lo) && (3'(b) <= hi);
    end
    return m;
  endfunction

  // Configuration registers: write them only while idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address  <= '0;
      present_pages <= 16'd32768;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BASE_ADDRESS:  base_address  <= cfg_data;
        REG_PRESENT_PAGES: present_pages <= cfg_data[15:0];
      endcase
    end
  end

  // Search limit: smallest of present_pages, the store size and the field limit.
  logic [PW-1:0] limit;
  always_comb begin
    if (PW'(present_pages) > PW'(LIMIT_CAP)) begin
      limit = PW'(LIMIT_CAP);
    end else begin
      limit = PW'(present_pages);
    end
  end

  // Request decode in the accept cycle, and the held page index widened.
  logic [PW-1:0] pi_ext;
  logic [PW-1:0] pi_q;
  logic [PW-1:0] end_clip;
  logic [PW-1:0] end_m1;
  always_comb begin
    pi_ext = PW'(request.page_index);
    pi_q   = PW'(req_q.page_index);
    if (PW'(request.range_end) > PW'(PAGES)) begin
      end_clip = PW'(PAGES);
    end else begin
      end_clip = PW'(request.range_end);
    end
    end_m1 = end_clip - 1'b1;
  end

  // Scan datapath: page number of the current byte and its first free bit.
  logic [PW-1:0] word_base;
  logic [PW-1:0] found_page;
  logic [2:0]    free_bit;
  logic [31:0]   found_addr;
  always_comb begin
    word_base  = PW'({cur, 3'b000});
    free_bit   = first_zero(rd_data);
    found_page = word_base | PW'(free_bit);
    found_addr = base_address + (32'(found_page[14:0]) << PAGE_SHIFT);
  end

  assign busy = clearing || (state != S_IDLE);

  always_comb begin
    state_next     = state;
    req_q_next     = req_q;
    cur_next       = cur;
    last_word_next = last_word;
    lo_bit_next    = lo_bit;
    hi_bit_next    = hi_bit;
    done_next      = 1'b0;
    result_next    = result;
    store_req      = '0;
    store_req.rd_addr = cur[AW-1:0];

    unique case (state)
      S_IDLE: begin
        if (start && !clearing) begin
          req_q_next = request;
          // Default answer, kept by every command but allocate.
          result_next.address        = '0;
          result_next.allocated_page = request.page_index;
          result_next.failed         = 1'b0;
          case (request.command)
            CMD_ALLOC: begin
              store_req.rd_addr = '0;
              cur_next          = '0;
              state_next        = S_SCAN;
            end
            CMD_FREE: begin
              if (pi_ext < PW'(PAGES)) begin
                store_req.rd_addr = pi_ext[AW+2:3];
                state_next        = S_FREE;
              end else begin
                done_next = 1'b1;            // beyond the store: drop
              end
            end
            CMD_RESERVE: begin
              if (pi_ext < end_clip) begin
                store_req.rd_addr = pi_ext[AW+2:3];
                cur_next          = (AW + 1)'(pi_ext[AW+2:3]);
                last_word_next    = end_m1[AW+2:3];
                lo_bit_next       = pi_ext[2:0];
                hi_bit_next       = end_m1[2:0];
                state_next        = S_RESV;
              end else begin
                done_next = 1'b1;            // empty or inverted range
              end
            end
            default: begin
              done_next = 1'b1;              // unused command
            end
          endcase
        end
      end

      S_SCAN: begin
        // rd_data holds byte cur; read ahead the next one on a full byte.
        if (word_base >= limit || (rd_data != FULL_BYTE && found_page >= limit)) begin
          result_next.address        = '0;
          result_next.allocated_page = '0;
          result_next.failed         = 1'b1;
          done_next                  = 1'b1;
          state_next                 = S_IDLE;
        end else if (rd_data == FULL_BYTE) begin
          cur_next          = cur + 1'b1;
          store_req.rd_addr = cur_next[AW-1:0];
        end else begin
          store_req.wr_en            = 1'b1;
          store_req.wr_addr          = cur[AW-1:0];
          store_req.wr_data          = rd_data | (8'b1 << free_bit);
          result_next.address        = found_addr;
          result_next.allocated_page = found_page[14:0];
          result_next.failed         = 1'b0;
          done_next                  = 1'b1;
          state_next                 = S_IDLE;
        end
      end

      S_FREE: begin
        store_req.wr_en   = 1'b1;
        store_req.wr_addr = pi_q[AW+2:3];
        store_req.wr_data = rd_data & ~(8'b1 << req_q.page_index[2:0]);
        done_next         = 1'b1;
        state_next        = S_IDLE;
      end

      S_RESV: begin
        // Write byte cur while the next one is read; bytes never repeat.
        store_req.wr_en   = 1'b1;
        store_req.wr_addr = cur[AW-1:0];
        store_req.wr_data = rd_data | span_mask(
          (cur[AW-1:0] == pi_q[AW+2:3]) ? lo_bit : 3'd0,
          (cur[AW-1:0] == last_word) ? hi_bit : 3'd7);
        if (cur[AW-1:0] == last_word) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          cur_next          = cur + 1'b1;
          store_req.rd_addr = cur_next[AW-1:0];
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // Payload: no reset needed.
  always_ff @(posedge clk) begin
    req_q     <= req_q_next;
    cur       <= cur_next;
    last_word <= last_word_next;
    lo_bit    <= lo_bit_next;
    hi_bit    <= hi_bit_next;
    result    <= result_next;
  end

`ifndef NO_ASSERTIONS
  // Hold the command logic still while the clearing pass owns the store.
  a_no_work_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (state == S_IDLE) && !done)
    else $error("request in progress during clearing pass");

  // An accepted allocate always enters the scan.
  a_alloc_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.command == CMD_ALLOC) |=> (state == S_SCAN))
    else $error("allocate request did not start a scan");

  // A failed allocate reports no page and no address.
  a_fail_is_clean: assert property (@(posedge clk) disable iff (rst)
    (done && result.failed) |-> (result.address == '0) && (result.allocated_page == '0))
    else $error("failed allocate carries a page or address");

  // Write the bitmap only from a working state.
  a_write_only_working: assert property (@(posedge clk) disable iff (rst)
    store_req.wr_en |-> (state != S_IDLE))
    else $error("bitmap write while idle");
`endif

endmodule
`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench for the first-fit bitmap page allocator.
`timescale 1ns / 1ps
module tb;
  import pba_pkg::*;

  // The package names the three live commands; the fourth code must be a no-op.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 3;
  localparam int BLOCK_ITEMS  = 100;
  localparam int BLOCKS       = 5;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int PRINT_CAP    = 200;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  request_t    request;
  logic        done;
  result_t     result;
  logic        cfg_write;
  logic        cfg_index;
  logic [31:0] cfg_data;

  // One line of the directed table: either a register write or a request,
  // with the answer typed in where it is obvious.
  typedef struct {
    bit          is_cfg;
    logic        cfg_idx;
    logic [31:0] cfg_val;
    request_t    req;
    bit          typed;
    result_t     want;
  } plan_row_t;

  // Shadow of the block: one used bit per page plus the two registers.
  bit          page_used [PAGES];
  logic [31:0] base_reg;
  logic [15:0] present_reg;

  result_t     pending_results [$];
  plan_row_t   plan [$];
  int          error_count;
  int          idle_pct;

  page_bitmap_allocator uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run, clearing pass included.
  initial begin
    repeat (30_000_000) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < PRINT_CAP)
      $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Apply one request to the shadow bitmap and return the answer it earns.
  function automatic result_t allocator_outcome(request_t req);
    result_t res;
    int      lim;
    int      stop;
    int      page;
    bit      found;
    res.address        = '0;
    res.allocated_page = req.page_index;
    res.failed         = 1'b0;
    page               = 0;
    found              = 1'b0;
    case (req.command)
      CMD_ALLOC: begin
        // Search below the present count, capped by the store and the
        // 15-bit page field.
        lim = int'(present_reg);
        if (lim > PAGES) lim = PAGES;
        if (lim > 32768) lim = 32768;
        for (int p = 0; p < lim && !found; p++) begin
          if (!page_used[p]) begin
            found = 1'b1;
            page  = p;
          end
        end
        if (found) begin
          page_used[page]    = 1'b1;
          res.address        = base_reg + (32'(page) << PAGE_SHIFT);
          res.allocated_page = 15'(page);
        end else begin
          res.failed         = 1'b1;
          res.allocated_page = '0;
        end
      end
      CMD_FREE: begin
        if (int'(req.page_index) < PAGES) page_used[req.page_index] = 1'b0;
      end
      CMD_RESERVE: begin
        // Half-open range, clipped to the store; empty or inverted marks nothing.
        stop = int'(req.range_end);
        if (stop > PAGES) stop = PAGES;
        for (int p = int'(req.page_index); p < stop; p++) page_used[p] = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic request_t make_request(logic [1:0] cmd, int page, int stop);
    request_t r;
    r.command    = cmd;
    r.page_index = 15'(page);
    r.range_end  = 16'(stop);
    return r;
  endfunction

  function automatic plan_row_t cfg_row(logic idx, logic [31:0] val);
    plan_row_t row;
    row         = '{default: '0};
    row.is_cfg  = 1'b1;
    row.cfg_idx = idx;
    row.cfg_val = val;
    return row;
  endfunction

  function automatic plan_row_t req_row(logic [1:0] cmd, int page, int stop);
    plan_row_t row;
    row     = '{default: '0};
    row.req = make_request(cmd, page, stop);
    return row;
  endfunction

  function automatic plan_row_t typed_row(logic [1:0] cmd, int page, int stop,
                                          logic [31:0] addr, int got_page, bit fail);
    plan_row_t row;
    row                     = req_row(cmd, page, stop);
    row.typed               = 1'b1;
    row.want.address        = addr;
    row.want.allocated_page = 15'(got_page);
    row.want.failed         = fail;
    return row;
  endfunction

  // Random request. Keep most pages and ranges low so scans stay short; a
  // few wide reserves land in the upper half to cover the long walk.
  function automatic request_t random_request();
    int pick;
    int first;
    int stop;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      return make_request(CMD_ALLOC, int'(15'($urandom)), int'(16'($urandom)));
    end else if (pick < 75) begin
      if ($urandom_range(0, 9) < 7) first = $urandom_range(0, 511);
      else first = int'(15'($urandom));
      return make_request(CMD_FREE, first, int'(16'($urandom)));
    end else if (pick < 95) begin
      if ($urandom_range(0, 9) < 8) begin
        first = $urandom_range(0, 500);
        if ($urandom_range(0, 9) == 0) stop = $urandom_range(0, first);
        else stop = first + $urandom_range(0, 24);
      end else begin
        first = 16384 + $urandom_range(0, 16383);
        stop  = int'(16'($urandom));
      end
      return make_request(CMD_RESERVE, first, stop);
    end
    return make_request(CMD_UNUSED, int'(15'($urandom)), int'(16'($urandom)));
  endfunction

  // Offer one request from a falling edge; hold it until busy is low at a
  // rising edge, then book the expected answer. Leave start high so a
  // following request can go back to back.
  task automatic send_request(input request_t req, input bit typed,
                              input result_t want);
    int      gap;
    result_t model_res;
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 8) : 0;
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   = 1'b1;
    request = req;
    do @(posedge clk); while (busy !== 1'b0);
    model_res = allocator_outcome(req);
    pending_results.push_back(typed ? want : model_res);
    @(negedge clk);
  endtask

  // Stop offering and let every outstanding request come back.
  task automatic drain_requests();
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Register write from a falling edge; the block takes it at the next rise.
  task automatic write_register(input logic idx, input logic [31:0] val);
    start     = 1'b0;
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_write = 1'b0;
    if (idx == REG_BASE_ADDRESS) base_reg = val;
    else present_reg = val[15:0];
  endtask

  // Check each strobed answer against the oldest booked one.
  always @(posedge clk) begin
    result_t want;
    if (rst === 1'b0 && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", result.address, '0);
      end else begin
        want = pending_results.pop_front();
        if (result.address !== want.address)
          report_mismatch("address", result.address, want.address);
        if (result.allocated_page !== want.allocated_page)
          report_mismatch("allocated_page", 32'(result.allocated_page),
                          32'(want.allocated_page));
        if (result.failed !== want.failed)
          report_mismatch("failed", 32'(result.failed), 32'(want.failed));
      end
    end
  end

  initial begin
    int          waited;
    logic [15:0] present_low;
    result_t     no_want;

    rst         = 1'b1;
    start       = 1'b0;
    request     = '0;
    cfg_write   = 1'b0;
    cfg_index   = REG_BASE_ADDRESS;
    cfg_data    = '0;
    base_reg    = '0;
    present_reg = 16'd32768;
    error_count = 0;
    idle_pct    = 11;
    no_want     = '0;

    // Directed table. Answers after reset, on failure, on two later frees and
    // on the unused command are typed; the rest come from the shadow model.
    plan.push_back(typed_row(CMD_ALLOC, 0, 0, 32'h0000_0000, 0, 1'b0));
    plan.push_back(typed_row(CMD_ALLOC, 32767, 65535, 32'h0000_1000, 1, 1'b0));
    plan.push_back(typed_row(CMD_FREE, 0, 0, 32'h0, 0, 1'b0));
    plan.push_back(typed_row(CMD_ALLOC, 0, 0, 32'h0000_0000, 0, 1'b0));
    plan.push_back(typed_row(CMD_RESERVE, 2, 10, 32'h0, 2, 1'b0));
    plan.push_back(req_row(CMD_ALLOC, 0, 0));
    // Empty and inverted ranges mark nothing.
    plan.push_back(req_row(CMD_RESERVE, 20, 20));
    plan.push_back(req_row(CMD_RESERVE, 30, 5));
    plan.push_back(req_row(CMD_ALLOC, 0, 0));
    plan.push_back(typed_row(CMD_FREE, 32767, 0, 32'h0, 32767, 1'b0));
    // Ranges that touch and overrun the top of the store.
    plan.push_back(req_row(CMD_RESERVE, 32760, 32768));
    plan.push_back(req_row(CMD_RESERVE, 32767, 65535));
    plan.push_back(typed_row(CMD_UNUSED, 15'h5AA5, 16'hFFFF, 32'h0, 15'h5AA5, 1'b0));
    // Small present count with a base that makes the address wrap.
    plan.push_back(cfg_row(REG_BASE_ADDRESS, 32'hFFFF_F000));
    plan.push_back(cfg_row(REG_PRESENT_PAGES, 32'd16));
    plan.push_back(req_row(CMD_ALLOC, 0, 0));
    plan.push_back(req_row(CMD_ALLOC, 0, 0));
    plan.push_back(req_row(CMD_ALLOC, 0, 0));
    plan.push_back(req_row(CMD_ALLOC, 0, 0));
    plan.push_back(typed_row(CMD_ALLOC, 0, 0, 32'h0, 0, 1'b1));
    plan.push_back(typed_row(CMD_FREE, 15, 0, 32'h0, 15, 1'b0));
    // No present pages at all: allocate always fails.
    plan.push_back(cfg_row(REG_PRESENT_PAGES, 32'd0));
    plan.push_back(typed_row(CMD_ALLOC, 0, 0, 32'h0, 0, 1'b1));
    // All-ones base and a present count beyond the store.
    plan.push_back(cfg_row(REG_BASE_ADDRESS, 32'hFFFF_FFFF));
    plan.push_back(cfg_row(REG_PRESENT_PAGES, 32'hFFFF_FFFF));
    plan.push_back(req_row(CMD_ALLOC, 0, 0));
    plan.push_back(req_row(CMD_ALLOC, 0, 0));
    plan.push_back(cfg_row(REG_BASE_ADDRESS, 32'h0));
    plan.push_back(cfg_row(REG_PRESENT_PAGES, 32'd32768));

    // Hold reset, then release it on a falling edge. The block
    // then clears its store with busy high; send_request waits that out.
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain_requests();
        write_register(plan[i].cfg_idx, plan[i].cfg_val);
      end else begin
        send_request(plan[i].req, plan[i].typed, plan[i].want);
      end
    end

    // Random part in three idle phases: sender idles 11%, then 48%, then
    // never. Each block of requests runs under a fresh register setting.
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 11 : (phase == 1) ? 48 : 0;
      for (int blk = 0; blk < BLOCKS; blk++) begin
        drain_requests();
        write_register(REG_BASE_ADDRESS, $urandom);
        // Mostly small counts keep scans short; zero and the top values
        // show up now and then. Upper data bits are random and must be dropped.
        case ($urandom_range(0, 9))
          0:       present_low = 16'd0;
          1:       present_low = 16'd32768;
          2:       present_low = 16'hFFFF;
          default: present_low = 16'($urandom_range(1, 400));
        endcase
        write_register(REG_PRESENT_PAGES, {16'($urandom), present_low});
        for (int n = 0; n < BLOCK_ITEMS; n++) begin
          // Occasionally hold off until every answer is back.
          if ($urandom_range(0, 99) == 0) drain_requests();
          send_request(random_request(), 1'b0, no_want);
        end
      end
    end

    // Drop start, collect what is still in flight, then idle a little.
    start  = 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0)
      report_mismatch("results never arrived", 32'(pending_results.size()), '0);
    repeat (8) @(posedge clk);

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/pba_pkg.sv
sv/pba_store.sv
sv/page_bitmap_allocator.sv
sim/tb.sv
